// ===== design/aes128_pkg.sv =====
// Package for the AES-128 block encryption pipeline.
// Holds shared types, sizes, the S-box table and the GF(2^8) helpers.
// No dependencies.
`default_nettype none

package aes128_pkg;

  // Number of rounds and size of the round key store.
  localparam int NumRounds = 10;
  localparam int KeyWords  = 2 * (NumRounds + 1);
  localparam int KeyIdxW   = 5;

  // Item kinds on the input channel.
  typedef enum logic {
    ModeLoad    = 1'b0,
    ModeEncrypt = 1'b1
  } mode_e;

  typedef logic [127:0] block_t;
  typedef logic [63:0]  word_t;

  // All eleven round keys, round k in element k.
  typedef logic [NumRounds:0][127:0] rkey_set_t;

  // Write request into the round key store.
  typedef struct packed {
    logic               en;
    logic [KeyIdxW-1:0] idx;
    word_t              data;
  } key_wr_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

`default_nettype wire

// ===== design/aes128_key_store.sv =====
// Round key store: 22 words of 64 bits, cleared at reset, one write per cycle.
// Presents all eleven 128-bit round keys in parallel to the round cells.
// Depends on aes128_pkg.
`default_nettype none

module aes128_key_store (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire aes128_pkg::key_wr_t  wr_i,
  output aes128_pkg::rkey_set_t     round_keys_o
);
  import aes128_pkg::*;

  word_t words_q [KeyWords];

  // Each word takes a write that names its slot; slots past the end are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) begin
        words_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < KeyWords; i++) begin
        if (wr_i.idx == KeyIdxW'(i)) begin
          words_q[i] <= wr_i.data;
        end
      end
    end
  end

  // Round k is the odd word above the even word.
  for (genvar k = 0; k <= NumRounds; k++) begin : g_round_key
    assign round_keys_o[k] = {words_q[2*k+1], words_q[2*k]};
  end

endmodule

`default_nettype wire

// ===== design/aes128_round_cell.sv =====
// One cell of the round chain: SubBytes, ShiftRows, optional MixColumns and
// AddRoundKey, registered, with its own valid bit. Depends on aes128_pkg.
`default_nettype none

module aes128_round_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire logic                last_round_i,
  input  wire logic                valid_i,
  input  wire aes128_pkg::block_t  state_i,
  input  wire aes128_pkg::block_t  round_key_i,
  output logic                     valid_o,
  output aes128_pkg::block_t       state_o
);
  import aes128_pkg::*;

  logic   valid_q;
  block_t state_q;
  block_t state_d;

  // Round function on the byte view: byte i sits at bits 8i+7 down to 8i.
  always_comb begin
    logic [7:0] sb [16];
    logic [7:0] mx [16];
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = Sbox[state_i[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c];
      a1 = sb[4*c + 1];
      a2 = sb[4*c + 2];
      a3 = sb[4*c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      mx[4*c]     = a0 ^ all ^ xtime(a0 ^ a1);
      mx[4*c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
      mx[4*c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
      mx[4*c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      state_d[8*i +: 8] = (last_round_i ? sb[i] : mx[i]) ^ round_key_i[8*i +: 8];
    end
  end

  // Valid bit of this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  // Block state held by this cell.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

`default_nettype wire

// ===== design/aes128_block_encrypt.sv =====
// Top level of the AES-128 block encryption pipeline.
// Instantiates aes128_key_store and ten aes128_round_cell; uses aes128_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes two kinds of item.
//   A load item (mode 0) writes block_low_i into round key word
//   key_word_index_i (slots 22 to 31 are ignored) and gives no result.
//   An encrypt item (mode 1) carries the plaintext as two little-endian
//   halves and gives one ciphertext item on the output channel
//   (out_valid_o / out_stall_i).
//   A ciphertext passes through the entry register, which takes the initial
//   key XOR of its plaintext, and then through each of the ten round cells.
//   Throughput: one encrypt item per cycle while the receiver does not stall,
//   set by the chain of ten registered round cells that all shift together.
//   A load item is held off while any block is still in the first ten
//   stages, so blocks in flight finish with the keys they started with.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and the input is stalled for encrypt items.
//   Reset clears all valid bits and sets every round key word to zero.
`default_nettype none

module aes128_block_encrypt (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic         mode_i,
  input  wire logic [4:0]   key_word_index_i,
  input  wire logic [63:0]  block_low_i,
  input  wire logic [63:0]  block_high_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [63:0]       cipher_low_o,
  output logic [63:0]       cipher_high_o
);
  import aes128_pkg::*;

  rkey_set_t          round_keys;
  key_wr_t            key_wr;
  logic               advance;
  logic               busy;
  logic               load_accept;
  logic               enc_accept;
  logic [NumRounds:0] stage_valid;
  block_t             stage_state [NumRounds+1];
  logic               stage0_valid_q;
  block_t             stage0_state_q;

  // The chain moves when the last cell is empty or its item is taken.
  assign advance = !stage_valid[NumRounds] || !out_stall_i;
  assign busy    = |stage_valid[NumRounds-1:0];

  // Loads wait for the rounds to drain; encrypts wait for the chain to move.
  assign in_stall_o  = (mode_i == ModeLoad) ? busy : !advance;
  assign load_accept = in_valid_i && !in_stall_o && (mode_i == ModeLoad);
  assign enc_accept  = in_valid_i && !in_stall_o && (mode_i == ModeEncrypt);

  // Round key store write port.
  always_comb begin
    key_wr.en   = load_accept;
    key_wr.idx  = key_word_index_i;
    key_wr.data = block_low_i;
  end

  aes128_key_store u_key_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (key_wr),
    .round_keys_o (round_keys)
  );

  // Entry stage: initial AddRoundKey with round key 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage0_valid_q <= 1'b0;
    end else if (advance) begin
      stage0_valid_q <= enc_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stage0_state_q <= {block_high_i, block_low_i} ^ round_keys[0];
    end
  end

  assign stage_valid[0] = stage0_valid_q;
  assign stage_state[0] = stage0_state_q;

  // Chain of round cells; the last one skips MixColumns.
  for (genvar k = 1; k <= NumRounds; k++) begin : g_cell
    aes128_round_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .advance_i    (advance),
      .last_round_i (1'(k == NumRounds)),
      .valid_i      (stage_valid[k-1]),
      .state_i      (stage_state[k-1]),
      .round_key_i  (round_keys[k]),
      .valid_o      (stage_valid[k]),
      .state_o      (stage_state[k])
    );
  end

  assign out_valid_o   = stage_valid[NumRounds];
  assign cipher_low_o  = stage_state[NumRounds][63:0];
  assign cipher_high_o = stage_state[NumRounds][127:64];

  // A key word never changes under a block that still has rounds to run.
  a_load_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_accept |-> !busy)
    else $error("key load accepted while blocks are in flight");

  // An encrypt item always enters the entry stage.
  a_enc_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_accept |=> stage_valid[0])
    else $error("accepted block missing from entry stage");

  // A result only appears after the cell before it held an item.
  a_out_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stage_valid[NumRounds]) |-> $past(stage_valid[NumRounds-1]))
    else $error("result appeared without a block in the previous cell");

  // A held chain keeps every valid bit.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stage_valid))
    else $error("chain valid bits changed while stalled");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for aes128_block_encrypt: round key loads and block encryption.
// Depends on aes128_pkg and the aes128_block_encrypt design; predicts ciphertexts itself.

module tb_top;
  import aes128_pkg::*;

  localparam int NumItems   = 550;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;
  localparam int MaxReports = 30;

  // One input item as the driver presents it.
  typedef struct packed {
    mode_e       mode;
    logic [4:0]  idx;
    logic [63:0] low;
    logic [63:0] high;
    logic        drain;
  } stim_item_t;

  // One ciphertext as the monitor expects it.
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } cipher_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        mode_i           = 1'b0;
  logic [4:0]  key_word_index_i = '0;
  logic [63:0] block_low_i      = '0;
  logic [63:0] block_high_i     = '0;
  logic        out_stall_i      = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] cipher_low_o;
  logic [63:0] cipher_high_o;

  stim_item_t        pending_items[$];
  cipher_t           cipher_expected[$];
  stim_item_t        cur_item;
  logic [21:0][63:0] round_keys_shadow = '0;
  logic [7:0]        sbox_tab [256];
  int                accept_count = 0;
  int                total_items  = 0;
  int                counted      = 0;
  int                fail_count   = 0;
  int                cycle_count  = 0;

  aes128_block_encrypt dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .key_word_index_i(key_word_index_i),
    .block_low_i     (block_low_i),
    .block_high_i    (block_high_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_low_o    (cipher_low_o),
    .cipher_high_o   (cipher_high_o)
  );

  // Free-running clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Doubling in GF(2^8) modulo the AES polynomial.
  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Idle percentage of one side for the current stretch of the run.
  function automatic int idle_pct(input bit sender);
    if (accept_count * 3 < total_items) return sender ? 8 : 46;
    if (accept_count * 3 < 2 * total_items) return sender ? 46 : 8;
    return 0;
  endfunction

  // Random 64-bit word with the two extremes weighted up.
  function automatic logic [63:0] rand_word();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Standard AES-128 key expansion, packed as 22 little-endian words.
  function automatic logic [21:0][63:0] expand_key(input logic [127:0] key);
    logic [175:0][7:0] kb;
    logic [3:0][7:0]   t;
    logic [3:0][7:0]   u;
    logic [7:0]        rc;
    kb = '0;
    kb[15:0] = key;
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = kb[i - 4 + j];
      if (i % 16 == 0) begin
        u[0] = sbox_tab[t[1]] ^ rc;
        u[1] = sbox_tab[t[2]];
        u[2] = sbox_tab[t[3]];
        u[3] = sbox_tab[t[0]];
        t = u;
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) kb[i + j] = kb[i - 16 + j] ^ t[j];
    end
    return kb;
  endfunction

  // AES-128 encryption of one block under a given expanded schedule.
  function automatic logic [127:0] encrypt_block(input logic [127:0] pt,
                                                 input logic [21:0][63:0] keys);
    logic [15:0][7:0] st;
    logic [15:0][7:0] t;
    logic [7:0]       a0, a1, a2, a3, all;
    st = pt ^ {keys[1], keys[0]};
    for (int r = 1; r <= 10; r++) begin
      // SubBytes and ShiftRows together.
      for (int row = 0; row < 4; row++)
        for (int c = 0; c < 4; c++)
          t[row + 4 * c] = sbox_tab[st[row + 4 * ((c + row) % 4)]];
      st = t;
      // MixColumns in every round but the last.
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4 * c];
          a1 = st[4 * c + 1];
          a2 = st[4 * c + 2];
          a3 = st[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
          st[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
          st[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
          st[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      st = st ^ {keys[2 * r + 1], keys[2 * r]};
    end
    return st;
  endfunction

  // Queue one item; loads to slots past the store do not count.
  task automatic push_item(input mode_e mode, input logic [4:0] idx,
                           input logic [63:0] low, input logic [63:0] high);
    stim_item_t it;
    it.mode  = mode;
    it.idx   = idx;
    it.low   = low;
    it.high  = high;
    it.drain = 1'b0;
    pending_items.push_back(it);
    if (!(mode == ModeLoad && idx >= KeyWords)) counted++;
  endtask

  // Full schedule load followed by a few blocks.
  task automatic push_schedule(input logic [21:0][63:0] sched, input int blocks);
    bit reverse;
    reverse = ($urandom_range(3) == 0);
    for (int k = 0; k < KeyWords; k++)
      push_item(ModeLoad, reverse ? 5'(KeyWords - 1 - k) : 5'(k), sched[reverse ?
                KeyWords - 1 - k : k], rand_word());
    for (int k = 0; k < blocks; k++)
      push_item(ModeEncrypt, 5'($urandom_range(31)), rand_word(), rand_word());
  endtask

  // Driver: presents queued items and updates the prediction on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (cur_item.mode == ModeLoad) begin
          if (cur_item.idx < KeyWords) round_keys_shadow[cur_item.idx] = cur_item.low;
        end else begin
          cipher_expected.push_back(encrypt_block({cur_item.high, cur_item.low},
                                                  round_keys_shadow));
        end
        accept_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct(1'b1) &&
            !(pending_items[0].drain && cipher_expected.size() != 0)) begin
          cur_item = pending_items.pop_front();
          in_valid_i       <= 1'b1;
          mode_i           <= cur_item.mode;
          key_word_index_i <= cur_item.idx;
          block_low_i      <= cur_item.low;
          block_high_i     <= cur_item.high;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each ciphertext with the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cipher_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: unexpected ciphertext expected none actual %h_%h",
                     $time, cipher_high_o, cipher_low_o);
        end else begin
          want = cipher_expected.pop_front();
          if (cipher_low_o !== want.low) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("%0t: cipher_low expected %h actual %h", $time, want.low,
                       cipher_low_o);
          end
          if (cipher_high_o !== want.high) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("%0t: cipher_high expected %h actual %h", $time, want.high,
                       cipher_high_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL aes128_block_encrypt");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [7:0]        a, b, p, inv;
    logic [21:0][63:0] sched;
    logic [127:0]      got;
    int                pick;
    int                n;

    // S-box from the multiplicative inverse and the affine map.
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        a = 8'(x);
        b = 8'(y);
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
          if (b[0]) p = p ^ a;
          a = gf_double(a);
          b = b >> 1;
        end
        if (p == 8'h01) inv = 8'(y);
      end
      sbox_tab[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end

    // Sanity of the predictor against the published example vector.
    sched = expand_key(128'h0f0e0d0c0b0a09080706050403020100);
    got = encrypt_block({64'hffeeddccbbaa9988, 64'h7766554433221100}, sched);
    if (got !== {64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469}) begin
      fail_count++;
      $display("%0t: example vector expected %h actual %h", $time,
               {64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469}, got);
    end

    // Directed items: zero keys, extremes, ignored slots, edge slots.
    push_item(ModeEncrypt, 5'd31, '0, '0);
    push_item(ModeEncrypt, 5'd0, '1, '1);
    push_item(ModeEncrypt, 5'd21, '1, '0);
    push_item(ModeLoad, 5'd22, '1, '1);
    push_item(ModeLoad, 5'd31, '1, '0);
    push_item(ModeEncrypt, 5'd10, '0, '0);
    push_item(ModeLoad, 5'd0, '1, '1);
    push_item(ModeLoad, 5'd21, '1, '0);
    push_item(ModeEncrypt, 5'd15, '1, '1);
    push_item(ModeLoad, 5'd21, '0, '1);
    push_item(ModeEncrypt, 5'd22, '0, '1);
    push_schedule(sched, 0);
    push_item(ModeEncrypt, 5'd0, 64'h7766554433221100, 64'hffeeddccbbaa9988);

    // Random part: mostly full schedules and block bursts.
    while (counted < NumItems) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_schedule(expand_key({$urandom, $urandom, $urandom, $urandom}),
                      $urandom_range(8, 1));
      end else if (pick < 75) begin
        n = $urandom_range(10, 1);
        for (int k = 0; k < n; k++)
          push_item(ModeEncrypt, 5'($urandom_range(31)), rand_word(), rand_word());
      end else if (pick < 92) begin
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++)
          push_item(ModeLoad, 5'($urandom_range(KeyWords - 1)), rand_word(), rand_word());
      end else begin
        n = $urandom_range(3, 1);
        for (int k = 0; k < n; k++)
          push_item(ModeLoad, 5'($urandom_range(31, KeyWords)), rand_word(), rand_word());
      end
      if ($urandom_range(99) < 3) pending_items[pending_items.size() - 1].drain = 1'b1;
    end

    // Drain the pipeline at each change of idling pattern.
    total_items = pending_items.size();
    pending_items[total_items / 3].drain = 1'b1;
    pending_items[(2 * total_items) / 3].drain = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i || cipher_expected.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (fail_count == 0 && cipher_expected.size() == 0) begin
      $display("PASS aes128_block_encrypt");
    end else begin
      $display("FAIL aes128_block_encrypt");
    end
    $finish;
  end

endmodule

// ===== aes128_block_encrypt.f =====
design/aes128_pkg.sv
design/aes128_key_store.sv
design/aes128_round_cell.sv
design/aes128_block_encrypt.sv
tb/tb_top.sv
